// ===== rtl/matrix_keypad_scanner_defines.svh =====
// Assertion macros shared by the checker of the keypad scanner.
`ifndef MATRIX_KEYPAD_SCANNER_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_DEFINES_SVH

// Checked on every rising edge once reset has been released.
`define MKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define MKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/mks_pkg.sv =====
package mks_pkg;

  // Keypad geometry.
  localparam int unsigned NumRows = 4;
  localparam int unsigned NumCols = 4;
  localparam int unsigned RowW    = $clog2(NumRows);
  localparam int unsigned ColW    = $clog2(NumCols);

  // Register field widths.
  localparam int unsigned PinW  = 16;
  localparam int unsigned DebW  = 8;
  localparam int unsigned SetW  = 8;
  localparam int unsigned WaitW = 10;
  localparam int unsigned KeyW  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [NumRows-1:0] RowsHigh = '1;

  // Configuration register indexes (column masks occupy 0 to NumCols-1).
  localparam logic [CfgIdxW-1:0] RegDebounce = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSettle   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTimeout  = 3'd6;

  // Reset values.
  localparam logic [DebW-1:0]  DebounceRst = 8'd20;
  localparam logic [SetW-1:0]  SettleRst   = 8'd3;
  localparam logic [WaitW-1:0] TimeoutRst  = 10'd500;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_SETTLE   = 3'd2,
    PH_RELEASE  = 3'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NO_HIT  = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  typedef struct packed {
    logic [NumCols-1:0][PinW-1:0] col_mask;
    logic [DebW-1:0]              debounce;
    logic [SetW-1:0]              settle;
    logic [WaitW-1:0]             timeout;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [ColW-1:0]   column_sel;
    logic [RowW-1:0]   row_sel;
    logic [WaitW-1:0]  wait_count;
    logic [KeyW-1:0]   held_key;
  } scan_state_t;

  typedef struct packed {
    logic [NumRows-1:0] row_drive;
    logic               busy;
    logic               done;
    logic [KeyW-1:0]    key_code;
    status_e            status;
  } scan_res_t;

  // ASCII code of the key at a given row and column.
  function automatic logic [KeyW-1:0] key_lookup(input logic [RowW-1:0] row,
                                                 input logic [ColW-1:0] col);
    logic [KeyW-1:0] key;
    case ({row, col})
      4'h0: key = 8'h31;  // 1
      4'h1: key = 8'h32;  // 2
      4'h2: key = 8'h33;  // 3
      4'h3: key = 8'h41;  // A
      4'h4: key = 8'h34;  // 4
      4'h5: key = 8'h35;  // 5
      4'h6: key = 8'h36;  // 6
      4'h7: key = 8'h42;  // B
      4'h8: key = 8'h37;  // 7
      4'h9: key = 8'h38;  // 8
      4'hA: key = 8'h39;  // 9
      4'hB: key = 8'h43;  // C
      4'hC: key = 8'h2A;  // *
      4'hD: key = 8'h30;  // 0
      4'hE: key = 8'h23;  // #
      default: key = 8'h44;  // D
    endcase
    return key;
  endfunction

endpackage

// ===== rtl/mks_step.sv =====
module mks_step import mks_pkg::*; (
  input  cfg_t               cfg_i,
  input  scan_state_t        state_i,
  input  logic               kind_i,
  input  logic [PinW-1:0]    event_pin_i,
  input  logic [NumCols-1:0] col_levels_i,
  output scan_state_t        state_o,
  output scan_res_t          res_o
);

  logic             pin_hit;
  logic [ColW-1:0]  pin_col;
  logic [WaitW-1:0] wait_dec;
  logic             wait_zero;
  logic             col_high;
  logic             last_row;
  logic [RowW-1:0]  row_next;

  // Column match: exact equality, the lowest matching column wins.
  always_comb begin
    pin_hit = 1'b0;
    pin_col = '0;
    for (int c = NumCols - 1; c >= 0; c--) begin
      if (cfg_i.col_mask[c] == event_pin_i) begin
        pin_hit = 1'b1;
        pin_col = ColW'(c);
      end
    end
  end

  // Shared conditions of the wait counter and the sampled column.
  assign wait_dec  = (state_i.wait_count != '0) ? state_i.wait_count - 1'b1 : '0;
  assign wait_zero = (wait_dec == '0);
  assign col_high  = col_levels_i[state_i.column_sel];
  assign last_row  = (state_i.row_sel == RowW'(NumRows - 1));
  assign row_next  = state_i.row_sel + 1'b1;

  // Next state.
  always_comb begin
    state_o = state_i;
    case (state_i.phase)
      PH_DEBOUNCE: begin
        if (!kind_i) begin
          state_o.wait_count = wait_dec;
          if (wait_zero) begin
            state_o.row_sel    = '0;
            state_o.wait_count = WaitW'(cfg_i.settle);
            state_o.phase      = PH_SETTLE;
          end
        end
      end
      PH_SETTLE: begin
        if (!kind_i) begin
          state_o.wait_count = wait_dec;
          if (wait_zero) begin
            if (!col_high) begin
              state_o.held_key   = key_lookup(state_i.row_sel, state_i.column_sel);
              state_o.wait_count = cfg_i.timeout;
              state_o.phase      = PH_RELEASE;
            end else if (last_row) begin
              state_o.phase = PH_IDLE;
            end else begin
              state_o.row_sel    = row_next;
              state_o.wait_count = WaitW'(cfg_i.settle);
            end
          end
        end
      end
      PH_RELEASE: begin
        if (!kind_i) begin
          if (col_high || state_i.wait_count == '0) begin
            state_o.phase = PH_IDLE;
          end else begin
            state_o.wait_count = state_i.wait_count - 1'b1;
          end
        end
      end
      default: begin
        // Idle, and any code outside the list, behaves as idle.
        state_o.phase = PH_IDLE;
        if (kind_i && pin_hit) begin
          state_o.column_sel = pin_col;
          state_o.wait_count = WaitW'(cfg_i.debounce);
          state_o.phase      = PH_DEBOUNCE;
        end
      end
    endcase
  end

  // Result word.
  always_comb begin
    res_o.row_drive = RowsHigh;
    res_o.busy      = 1'b1;
    res_o.done      = 1'b0;
    res_o.key_code  = '0;
    res_o.status    = ST_FOUND;
    case (state_i.phase)
      PH_DEBOUNCE: begin
        if (!kind_i && wait_zero) begin
          res_o.row_drive = ~NumRows'(1);
        end
      end
      PH_SETTLE: begin
        if (kind_i || !wait_zero) begin
          res_o.row_drive = ~(NumRows'(1) << state_i.row_sel);
        end else if (col_high && last_row) begin
          res_o.busy   = 1'b0;
          res_o.done   = 1'b1;
          res_o.status = ST_NO_HIT;
        end else if (col_high) begin
          res_o.row_drive = ~(NumRows'(1) << row_next);
        end
      end
      PH_RELEASE: begin
        if (!kind_i && (col_high || state_i.wait_count == '0)) begin
          res_o.busy     = 1'b0;
          res_o.done     = 1'b1;
          res_o.key_code = state_i.held_key;
        end
      end
      default: begin
        if (!kind_i) begin
          res_o.busy = 1'b0;
        end else if (!pin_hit) begin
          res_o.busy   = 1'b0;
          res_o.done   = 1'b1;
          res_o.status = ST_UNKNOWN;
        end
      end
    endcase
  end

endmodule

// ===== rtl/matrix_keypad_scanner.sv =====
// Scanner for a 4x4 matrix keypad.
// Input channel (in_valid_i / in_stall_o): one word per millisecond tick
// (kind_i low, col_levels_i sampled) or per column interrupt (kind_i high,
// event_pin_i carries the pin mask).
// Output channel (out_valid_o / out_stall_i): exactly one result word per
// input word, in order: row levels, busy, done, key code and scan status.
// Configuration: a write on cfg_we_i stores cfg_data_i into register
// cfg_idx_i (column masks, debounce, settle, release timeout); an index
// past the list is ignored. Write only while the scanner is idle.
// Result: each result word is registered and shown in the cycle after its input word is taken.
// Throughput: one word per cycle while in_stall_o is low; the scan state and
// the result register are both updated in the cycle the word is taken.
// Stall: the result register holds its word while out_stall_i is high, and
// in_stall_o rises only while a held word is still waiting to be taken.
// Reset: the scanner goes idle, the output register empties and all
// configuration registers return to their defaults.
module matrix_keypad_scanner import mks_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [PinW-1:0]     event_pin_i,
  input  logic [NumCols-1:0]  col_levels_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [NumRows-1:0]  row_drive_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic [KeyW-1:0]     key_code_o,
  output logic [1:0]          scan_status_o
);

  cfg_t        cfg_q;
  scan_state_t state_q, state_d;
  scan_res_t   res_q, res_d;
  logic        out_valid_q;
  logic        in_fire;

  // A new word is taken unless a finished one is still held.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCols; c++) begin
        cfg_q.col_mask[c] <= PinW'(1) << c;
      end
      cfg_q.debounce <= DebounceRst;
      cfg_q.settle   <= SettleRst;
      cfg_q.timeout  <= TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDebounce: cfg_q.debounce <= cfg_data_i[DebW-1:0];
        RegSettle:   cfg_q.settle   <= cfg_data_i[SetW-1:0];
        RegTimeout:  cfg_q.timeout  <= cfg_data_i[WaitW-1:0];
        default: begin
          if (cfg_idx_i < CfgIdxW'(NumCols)) begin
            cfg_q.col_mask[cfg_idx_i[ColW-1:0]] <= cfg_data_i[PinW-1:0];
          end
        end
      endcase
    end
  end

  // Per-word state update and result.
  mks_step u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .kind_i       (kind_i),
    .event_pin_i  (event_pin_i),
    .col_levels_i (col_levels_i),
    .state_o      (state_d),
    .res_o        (res_d)
  );

  // Scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_drive_o   = res_q.row_drive;
  assign busy_res_o    = res_q.busy;
  assign done_res_o    = res_q.done;
  assign key_code_o    = res_q.key_code;
  assign scan_status_o = res_q.status;

endmodule

// ===== rtl/mks_checker.sv =====
`include "matrix_keypad_scanner_defines.svh"

module mks_checker import mks_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [NumRows-1:0] row_drive_o,
  input logic               busy_res_o,
  input logic               done_res_o,
  input logic [KeyW-1:0]    key_code_o,
  input logic [1:0]         scan_status_o
);

  logic key_shown;
  logic key_ok;
  logic row_low;
  logic row_ok;

  // Conditions on the result word shown at the output.
  assign key_shown = out_valid_o && (key_code_o != '0);
  assign key_ok    = done_res_o && !busy_res_o && (scan_status_o == ST_FOUND);
  assign row_low   = out_valid_o && (row_drive_o != '1);
  assign row_ok    = ($countones(~row_drive_o) == 1) && busy_res_o && !done_res_o;

  // The output register is empty while reset is held.
  `MKS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "word valid during reset")

  // The input side is held off only by a waiting result word.
  `MKS_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "stall without cause")

  // A word that shows a key is done, not busy, and carries a found status.
  `MKS_ASSERT(a_done_key, key_shown |-> key_ok, "key outside a found result")

  // At most one row is driven low, and only during a scan.
  `MKS_ASSERT(a_row_drive, row_low |-> row_ok, "bad row drive")

  // A stalled result word holds.
  `MKS_ASSERT(a_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(key_code_o) && $stable(row_drive_o), "stalled word changed")

endmodule

bind matrix_keypad_scanner mks_checker u_mks_checker (.*);
